### design/rwhp_pkg.sv
// shared types and constants for the riff/wave header parser
package rwhp_pkg;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;

   localparam logic [4:0]  FMT_BYTES = 5'd16;
   localparam logic [4:0]  CHUNK_HDR_BYTES = 5'd8;

   localparam logic [3:0] ST_OK           = 4'd0;
   localparam logic [3:0] ST_NO_HEADER    = 4'd1;
   localparam logic [3:0] ST_SHORT_PAGE   = 4'd2;
   localparam logic [3:0] ST_DATA_NO_FMT  = 4'd3;
   localparam logic [3:0] ST_ALAW         = 4'd4;
   localparam logic [3:0] ST_ULAW         = 4'd5;
   localparam logic [3:0] ST_UNKNOWN_ENC  = 4'd6;
   localparam logic [3:0] ST_BAD_CHANNELS = 4'd7;
   localparam logic [3:0] ST_BAD_BITS     = 4'd8;

   localparam logic [15:0] ENC_PCM  = 16'd1;
   localparam logic [15:0] ENC_ALAW = 16'd6;
   localparam logic [15:0] ENC_ULAW = 16'd7;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_CHUNK,
      PH_FMT,
      PH_SKIP
   } phase_type;

   typedef struct packed {
      logic       page_start;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [15:0] data_start;
      logic [31:0] data_length;
      logic [26:0] frame_bytes;
      logic [14:0] channel_count;
      logic [31:0] sample_rate;
      logic [14:0] sample_bits;
   } rsp_type;

endpackage

### design/rwhp_parser.sv
// chunk walker: parse state, per-byte decode and result formation
module rwhp_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  rwhp_pkg::req_type item,
   input  logic [15:0]       page_length,
   output logic              res_valid,
   output rwhp_pkg::rsp_type res
);

   logic [31:0]         pos_ff, pos_in;
   rwhp_pkg::phase_type phase_ff, phase_in;
   logic [31:0]         asm_ff, asm_in;
   logic [31:0]         tag_ff, tag_in;
   logic [31:0]         size_ff, size_in;
   logic [31:0]         skip_ff, skip_in;
   logic [4:0]          pc_ff, pc_in;
   logic [14:0]         chan_ff, chan_in;
   logic [31:0]         rate_ff, rate_in;
   logic [14:0]         bits_ff, bits_in;
   logic                fmt_seen_ff, fmt_seen_in;
   logic                finished_ff, finished_in;

   // effective state: page_start restarts from a clean parse
   logic [31:0]         eff_pos, eff_asm, eff_tag, eff_size, eff_skip, eff_rate;
   rwhp_pkg::phase_type eff_phase;
   logic [4:0]          eff_pc;
   logic [14:0]         eff_chan, eff_bits;
   logic                eff_fmt_seen;

   logic        active;
   logic [31:0] asm_new;
   logic [15:0] half;
   logic [4:0]  pc_new;
   logic [31:0] cs_new;
   logic [32:0] pn;
   logic [33:0] fmt_end;
   logic        goto_req;
   logic [31:0] goto_off;
   logic [33:0] hdr_end;
   logic        goto_fail;
   logic        err_req;
   logic [3:0]  err_code;
   logic        ok_req;
   logic        fmt_enter;
   logic [15:0] bytes_up;
   logic [12:0] bytes_per_sample;
   logic [27:0] frame_prod;

   always_comb begin
      if (item.page_start) begin
         eff_pos      = '0;
         eff_phase    = rwhp_pkg::PH_HEADER;
         eff_asm      = '0;
         eff_tag      = '0;
         eff_size     = '0;
         eff_skip     = '0;
         eff_pc       = '0;
         eff_chan     = '0;
         eff_rate     = '0;
         eff_bits     = '0;
         eff_fmt_seen = 1'b0;
      end else begin
         eff_pos      = pos_ff;
         eff_phase    = phase_ff;
         eff_asm      = asm_ff;
         eff_tag      = tag_ff;
         eff_size     = size_ff;
         eff_skip     = skip_ff;
         eff_pc       = pc_ff;
         eff_chan     = chan_ff;
         eff_rate     = rate_ff;
         eff_bits     = bits_ff;
         eff_fmt_seen = fmt_seen_ff;
      end
   end

   assign active  = step && (item.page_start || !finished_ff);
   assign asm_new = {item.data_byte, eff_asm[31:8]};
   assign half    = asm_new[31:16];
   assign pc_new  = eff_pc + 5'd1;
   assign cs_new  = asm_new + {31'd0, asm_new[0]};
   assign pn      = {1'b0, eff_pos} + 33'd1;
   assign fmt_end = {1'b0, pn} + {2'b00, cs_new};

   // decode of the current byte into events
   always_comb begin
      goto_req  = 1'b0;
      goto_off  = '0;
      err_req   = 1'b0;
      err_code  = rwhp_pkg::ST_OK;
      ok_req    = 1'b0;
      fmt_enter = 1'b0;
      case (eff_phase)
         rwhp_pkg::PH_HEADER: begin
            if (eff_pos == 32'd11) begin
               if (eff_tag != rwhp_pkg::TAG_RIFF || asm_new != rwhp_pkg::TAG_WAVE) begin
                  err_req  = 1'b1;
                  err_code = rwhp_pkg::ST_NO_HEADER;
               end else begin
                  goto_req = 1'b1;
               end
            end
         end
         rwhp_pkg::PH_CHUNK: begin
            if (pc_new == rwhp_pkg::CHUNK_HDR_BYTES) begin
               if (eff_tag == rwhp_pkg::TAG_DATA) begin
                  if (!eff_fmt_seen) begin
                     err_req  = 1'b1;
                     err_code = rwhp_pkg::ST_DATA_NO_FMT;
                  end else begin
                     ok_req = 1'b1;
                  end
               end else if (eff_tag == rwhp_pkg::TAG_FMT) begin
                  if (fmt_end >= {18'd0, page_length}) begin
                     err_req  = 1'b1;
                     err_code = rwhp_pkg::ST_SHORT_PAGE;
                  end else begin
                     fmt_enter = 1'b1;
                  end
               end else begin
                  goto_req = 1'b1;
                  goto_off = cs_new;
               end
            end
         end
         rwhp_pkg::PH_FMT: begin
            if (pc_new == 5'd2) begin
               err_req = (half != rwhp_pkg::ENC_PCM);
               if (half == rwhp_pkg::ENC_ALAW) begin
                  err_code = rwhp_pkg::ST_ALAW;
               end else if (half == rwhp_pkg::ENC_ULAW) begin
                  err_code = rwhp_pkg::ST_ULAW;
               end else begin
                  err_code = rwhp_pkg::ST_UNKNOWN_ENC;
               end
            end else if (pc_new == 5'd4) begin
               err_req  = (half == 16'd0) || half[15];
               err_code = rwhp_pkg::ST_BAD_CHANNELS;
            end else if (pc_new == rwhp_pkg::FMT_BYTES) begin
               if (half == 16'd0 || half[15]) begin
                  err_req  = 1'b1;
                  err_code = rwhp_pkg::ST_BAD_BITS;
               end else begin
                  goto_req = 1'b1;
                  // short fmt chunks skip nothing
                  goto_off = (eff_size > 32'd16) ? (eff_size - 32'd16) : 32'd0;
               end
            end
         end
         rwhp_pkg::PH_SKIP: begin
            goto_req = 1'b0;
         end
         default: begin
            goto_req = 1'b0;
         end
      endcase
   end

   assign hdr_end   = {1'b0, pn} + {2'b00, goto_off} + 34'd8;
   assign goto_fail = goto_req && (hdr_end >= {18'd0, page_length});

   // next state
   always_comb begin
      pos_in      = pos_ff;
      phase_in    = phase_ff;
      asm_in      = asm_ff;
      tag_in      = tag_ff;
      size_in     = size_ff;
      skip_in     = skip_ff;
      pc_in       = pc_ff;
      chan_in     = chan_ff;
      rate_in     = rate_ff;
      bits_in     = bits_ff;
      fmt_seen_in = fmt_seen_ff;
      finished_in = finished_ff;
      if (active) begin
         pos_in      = eff_pos + 32'd1;
         phase_in    = eff_phase;
         asm_in      = asm_new;
         tag_in      = eff_tag;
         size_in     = eff_size;
         skip_in     = eff_skip;
         pc_in       = eff_pc;
         chan_in     = eff_chan;
         rate_in     = eff_rate;
         bits_in     = eff_bits;
         fmt_seen_in = eff_fmt_seen;
         finished_in = err_req || goto_fail || ok_req;
         case (eff_phase)
            rwhp_pkg::PH_HEADER: begin
               if (eff_pos == 32'd3) begin
                  tag_in = asm_new;
               end
            end
            rwhp_pkg::PH_CHUNK: begin
               pc_in = pc_new;
               if (pc_new == 5'd4) begin
                  tag_in = asm_new;
               end
               if (pc_new == rwhp_pkg::CHUNK_HDR_BYTES) begin
                  size_in = cs_new;
               end
               if (fmt_enter) begin
                  phase_in = rwhp_pkg::PH_FMT;
                  pc_in    = '0;
               end
            end
            rwhp_pkg::PH_FMT: begin
               pc_in = pc_new;
               if (pc_new == 5'd4) begin
                  chan_in = half[14:0];
               end else if (pc_new == 5'd8) begin
                  rate_in = asm_new;
               end else if (pc_new == rwhp_pkg::FMT_BYTES) begin
                  bits_in     = half[14:0];
                  fmt_seen_in = 1'b1;
               end
            end
            rwhp_pkg::PH_SKIP: begin
               skip_in = eff_skip - 32'd1;
               if (eff_skip == 32'd1) begin
                  phase_in = rwhp_pkg::PH_CHUNK;
                  pc_in    = '0;
               end
            end
            default: begin
               phase_in = rwhp_pkg::PH_HEADER;
            end
         endcase
         if (goto_req) begin
            skip_in  = goto_off;
            pc_in    = '0;
            phase_in = (goto_off != 32'd0) ? rwhp_pkg::PH_SKIP : rwhp_pkg::PH_CHUNK;
         end
      end
   end

   // result
   assign bytes_up         = {1'b0, eff_bits} + 16'd7;
   assign bytes_per_sample = bytes_up[15:3];
   assign frame_prod       = {15'd0, bytes_per_sample} * {13'd0, eff_chan};

   always_comb begin
      res_valid = active && (err_req || goto_fail || ok_req);
      res       = '0;
      if (ok_req) begin
         res.status        = rwhp_pkg::ST_OK;
         res.data_start    = pn[15:0];
         res.data_length   = cs_new;
         res.frame_bytes   = frame_prod[26:0];
         res.channel_count = eff_chan;
         res.sample_rate   = eff_rate;
         res.sample_bits   = eff_bits;
      end else if (goto_fail) begin
         res.status = rwhp_pkg::ST_SHORT_PAGE;
      end else begin
         res.status = err_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         phase_ff    <= rwhp_pkg::PH_HEADER;
         asm_ff      <= '0;
         tag_ff      <= '0;
         size_ff     <= '0;
         skip_ff     <= '0;
         pc_ff       <= '0;
         chan_ff     <= '0;
         rate_ff     <= '0;
         bits_ff     <= '0;
         fmt_seen_ff <= 1'b0;
         finished_ff <= 1'b1;
      end else begin
         pos_ff      <= pos_in;
         phase_ff    <= phase_in;
         asm_ff      <= asm_in;
         tag_ff      <= tag_in;
         size_ff     <= size_in;
         skip_ff     <= skip_in;
         pc_ff       <= pc_in;
         chan_ff     <= chan_in;
         rate_ff     <= rate_in;
         bits_ff     <= bits_in;
         fmt_seen_ff <= fmt_seen_in;
         finished_ff <= finished_in;
      end
   end

endmodule

### design/riff_wave_header_parser_core.sv
// top level: byte input register, chunk parser, result register, page length csr
//
//  channel | dir | payload                  | beat
//  req     | in  | rwhp_pkg::req_type       | one page byte, page_start marks byte 0
//  rsp     | out | rwhp_pkg::rsp_type       | one status/format result per page
//  csr     | in  | csr_page_length [15:0]   | page length write
//
// one byte per cycle unless a held result stalls; each result is registered
// the throughput is set by the combinational parser step between the two registers
// after reset the parser idles until a byte with page_start, page length reads 0
// rsp_ready low holds the result; the input register takes one more beat, then
// req_ready drops until the result is taken
module riff_wave_header_parser_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rwhp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rwhp_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_page_length
);

   logic              in_valid_ff, in_valid_in;
   rwhp_pkg::req_type in_item_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rwhp_pkg::rsp_type rsp_data_ff;
   logic [15:0]       page_length_ff;

   logic              advance;
   logic              res_valid;
   rwhp_pkg::rsp_type res;

   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign csr_ready   = 1'b1;

   // a slot drained without a new result goes empty
   assign rsp_valid_in = advance ? res_valid : (rsp_valid_ff && !rsp_ready);

   rwhp_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .item        (in_item_ff),
      .page_length (page_length_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         page_length_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            page_length_ff <= csr_page_length;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (advance && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("held byte lost while output stalled");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != rwhp_pkg::ST_OK) |->
         (rsp_data.data_length == 32'd0 && rsp_data.channel_count == 15'd0 &&
          rsp_data.sample_rate == 32'd0 && rsp_data.data_start == 16'd0))
      else $error("error result carries nonzero fields");

   a_ok_format: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == rwhp_pkg::ST_OK) |->
         (rsp_data.channel_count != 15'd0 && rsp_data.sample_bits != 15'd0))
      else $error("ok result without valid format");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !advance)
      else $error("parser stepped while result slot blocked");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status <= rwhp_pkg::ST_BAD_BITS))
      else $error("status code out of range");

endmodule
